// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the token splitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define CTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("token splitter assertion failed");

// Checked at every rising edge, reset included.
`define CTS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("token splitter assertion failed");

`endif

// ===== rtl/cts_pkg.sv =====
// Shared types, constants and classification functions of the token splitter.
package cts_pkg;

	localparam int LINE_BITS  = 16;
	localparam int RES_MAX    = 3;
	localparam int CNT_BITS   = $clog2(RES_MAX + 1);
	localparam int IDX_BITS   = $clog2(RES_MAX);
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	typedef struct packed {
		logic [7:0]           token_byte;
		logic                 token_first;
		logic                 token_last;
		logic [LINE_BITS-1:0] line_number;
		logic                 end_of_source;
	} entry_t;

	typedef struct packed {
		entry_t [RES_MAX-1:0] ent;
		logic [CNT_BITS-1:0]  cnt;
	} rec_t;

	typedef struct packed {
		logic [7:0]           before_held;
		logic                 before_valid;
		logic                 inside_word;
		logic                 line_mode;
		logic                 block_mode;
		logic                 pair_due;
		logic [LINE_BITS-1:0] line_count;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		logic       emit;
		entry_t     ent;
	} proc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

	localparam lex_state_t LEX_RESET = '{
		before_held:  8'h00,
		before_valid: 1'b0,
		inside_word:  1'b0,
		line_mode:    1'b0,
		block_mode:   1'b0,
		pair_due:     1'b0,
		line_count:   LINE_BITS'(1)
	};

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_single_op(logic [7:0] c);
		logic r;
		case (c)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_AMP, CH_PIPE,
			CH_CARET, CH_EQ, CH_LT, CH_GT, CH_BANG, CH_TILDE, CH_COMMA,
			CH_SEMI, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
			CH_LBRACE, CH_RBRACE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_pair(logic [7:0] a, logic [7:0] b);
		logic r;
		if (b == CH_EQ) begin
			r = (a == CH_EQ) || (a == CH_BANG) || (a == CH_LT) || (a == CH_GT);
		end else begin
			r = (a == b) && ((a == CH_PIPE) || (a == CH_AMP) || (a == CH_LT) ||
				(a == CH_GT));
		end
		return r;
	endfunction

	// Classifies one byte c with optional lookahead nx against the lexer state.
	function automatic proc_t lex_step(lex_state_t st, logic [7:0] c, logic has_next,
			logic [7:0] nx);
		proc_t r;
		logic  word_last;
		r.st                = st;
		r.emit              = 1'b0;
		r.ent.token_byte    = c;
		r.ent.token_first   = 1'b0;
		r.ent.token_last    = 1'b0;
		r.ent.line_number   = st.line_count;
		r.ent.end_of_source = 1'b0;
		word_last = !has_next || is_space(nx) || is_single_op(nx);
		if (st.pair_due) begin
			r.st.pair_due     = 1'b0;
			r.emit            = 1'b1;
			r.ent.token_last  = 1'b1;
		end else if (st.line_mode) begin
			if (c == CH_LF) begin
				r.st.line_mode = 1'b0;
			end
		end else if (st.block_mode) begin
			if ((c == CH_SLASH) && st.before_valid && (st.before_held == CH_STAR)) begin
				r.st.block_mode = 1'b0;
			end
		end else if (is_space(c)) begin
			r.emit = 1'b0;
		end else if ((c == CH_SLASH) && has_next && (nx == CH_SLASH)) begin
			r.st.line_mode = 1'b1;
		end else if ((c == CH_SLASH) && has_next && (nx == CH_STAR)) begin
			r.st.block_mode = 1'b1;
		end else if (has_next && is_pair(c, nx)) begin
			r.st.pair_due     = 1'b1;
			r.emit            = 1'b1;
			r.ent.token_first = 1'b1;
		end else if (is_single_op(c)) begin
			r.emit            = 1'b1;
			r.ent.token_first = 1'b1;
			r.ent.token_last  = 1'b1;
		end else begin
			r.emit            = 1'b1;
			r.ent.token_first = !st.inside_word;
			r.ent.token_last  = word_last;
			r.st.inside_word  = !word_last;
		end
		if ((c == CH_LF) && (st.line_count != {LINE_BITS{1'b1}})) begin
			r.st.line_count = st.line_count + LINE_BITS'(1);
		end
		r.st.before_held  = c;
		r.st.before_valid = 1'b1;
		return r;
	endfunction

endpackage

// ===== rtl/cts_front.sv =====
// Front end: takes source words, keeps the lookahead byte and builds result records.
module cts_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            source_byte,
	input  logic                  final_byte,
	input  cts_pkg::fifo_status_t stat,
	output logic                  wr_en,
	output cts_pkg::rec_t         wr_rec
);

	cts_pkg::lex_state_t st_q;
	logic [7:0]          held_q;
	logic                held_valid_q;
	cts_pkg::proc_t      p_held;
	cts_pkg::proc_t      p_new;
	cts_pkg::lex_state_t st_mid;
	cts_pkg::entry_t     eos_ent;
	logic                e0;
	logic                e1;
	logic                accept;

	assign full   = stat.full;
	assign accept = push && !stat.full;

	always_comb begin
		p_held = cts_pkg::lex_step(st_q, held_q, 1'b1, source_byte);
		e0     = held_valid_q && p_held.emit;
		st_mid = held_valid_q ? p_held.st : st_q;
		p_new  = cts_pkg::lex_step(st_mid, source_byte, 1'b0, 8'h00);
		e1     = final_byte && p_new.emit;

		eos_ent.token_byte    = 8'h00;
		eos_ent.token_first   = 1'b0;
		eos_ent.token_last    = 1'b0;
		eos_ent.line_number   = p_new.st.line_count;
		eos_ent.end_of_source = 1'b1;

		// Pack the emitted results toward slot zero, oldest first.
		wr_rec.ent[2] = eos_ent;
		wr_rec.ent[1] = (e0 && e1) ? p_new.ent : eos_ent;
		wr_rec.ent[0] = e0 ? p_held.ent : (e1 ? p_new.ent : eos_ent);
		wr_rec.cnt    = cts_pkg::CNT_BITS'(e0) + cts_pkg::CNT_BITS'(e1) +
			cts_pkg::CNT_BITS'(final_byte);
		wr_en = accept && (wr_rec.cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= cts_pkg::LEX_RESET;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (final_byte) begin
				st_q         <= cts_pkg::LEX_RESET;
				held_q       <= 8'h00;
				held_valid_q <= 1'b0;
			end else begin
				st_q         <= st_mid;
				held_q       <= source_byte;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cts_fifo.sv =====
// Short record queue between the front end and the back end.
`include "assert_macros.svh"

module cts_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  cts_pkg::rec_t         wr_rec,
	input  logic                  rd_en,
	output cts_pkg::rec_t         head,
	output cts_pkg::fifo_status_t stat
);

	cts_pkg::rec_t                    mem_q [cts_pkg::FIFO_DEPTH];
	logic [cts_pkg::PTR_BITS-1:0]     wr_ptr_q;
	logic [cts_pkg::PTR_BITS-1:0]     rd_ptr_q;
	logic [cts_pkg::FCNT_BITS-1:0]    count_q;
	logic                             do_wr;
	logic                             do_rd;

	localparam logic [cts_pkg::PTR_BITS-1:0] PTR_LAST =
		cts_pkg::PTR_BITS'(cts_pkg::FIFO_DEPTH - 1);
	localparam logic [cts_pkg::FCNT_BITS-1:0] CNT_FULL =
		cts_pkg::FCNT_BITS'(cts_pkg::FIFO_DEPTH);

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 :
					wr_ptr_q + cts_pkg::PTR_BITS'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 :
					rd_ptr_q + cts_pkg::PTR_BITS'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + cts_pkg::FCNT_BITS'(1);
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - cts_pkg::FCNT_BITS'(1);
			end
		end
	end

	`CTS_ASSERT(a_count_bounded, clk, arst_n, count_q <= CNT_FULL)
	`CTS_ASSERT(a_no_empty_record, clk, arst_n, wr_en |-> (wr_rec.cnt != '0))
	`CTS_ASSERT(a_no_write_when_full, clk, arst_n, wr_en |-> !stat.full)

endmodule

// ===== rtl/cts_back.sv =====
// Back end: hands out the results of the head record one word at a time.
`include "assert_macros.svh"

module cts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cts_pkg::rec_t                 head,
	input  cts_pkg::fifo_status_t         stat,
	output logic                          rd_en,
	input  logic                          pop,
	output logic                          empty,
	output logic [7:0]                    token_byte,
	output logic                          token_first,
	output logic                          token_last,
	output logic [cts_pkg::LINE_BITS-1:0] line_number,
	output logic                          end_of_source,
	output logic                          run_last
);

	logic [cts_pkg::IDX_BITS-1:0] idx_q;
	cts_pkg::entry_t              cur;
	logic                         take;

	assign empty         = stat.empty;
	assign cur           = head.ent[idx_q];
	assign token_byte    = cur.token_byte;
	assign token_first   = cur.token_first;
	assign token_last    = cur.token_last;
	assign line_number   = cur.line_number;
	assign end_of_source = cur.end_of_source;
	assign run_last      = (idx_q == cts_pkg::IDX_BITS'(head.cnt - cts_pkg::CNT_BITS'(1)));
	assign take          = pop && !stat.empty;
	assign rd_en         = take && run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= run_last ? '0 : idx_q + cts_pkg::IDX_BITS'(1);
		end
	end

	`CTS_ASSERT(a_idx_in_range, clk, arst_n,
		!stat.empty |-> (cts_pkg::CNT_BITS'(idx_q) < head.cnt))
	`CTS_ASSERT(a_eos_ends_run, clk, arst_n, (!stat.empty && end_of_source) |-> run_last)

endmodule

// ===== rtl/c_style_token_splitter.sv =====
// Top level of the C-style token splitter: front end, record queue and back end.
//
// The splitter takes one source word per cycle while full is low and keeps the
// previous byte as lookahead, so a byte is classified, and its token word
// produced, in the cycle in which the byte after it arrives. Whitespace, line
// comments and block comments are dropped; word tokens, the eight two-character
// operators and the single-character operators come out one byte per result word,
// with first and last marks and the line number at that point. A source word
// flagged as final flushes the lookahead, classifies itself with no lookahead,
// and adds an end-of-source word, so it can yield up to three result words; all
// lexer state then returns to reset, and the next word starts a new source on
// line one. The front end accepts a word in every cycle in which full is low and
// writes the record of its results into a four-entry queue; full rises only when
// that queue is full, which happens when the consumer holds off pop or drains a
// final word's three results at one word per cycle. A result enters the queue
// when its word is accepted and is shown once earlier results are popped; the
// back end delivers one result word per cycle while pop is high and not empty.
module c_style_token_splitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    source_byte,
	input  logic                          final_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    token_byte,
	output logic                          token_first,
	output logic                          token_last,
	output logic [cts_pkg::LINE_BITS-1:0] line_number,
	output logic                          end_of_source,
	output logic                          run_last
);

	// Queue write side, driven by the front end.
	logic                  wr_en;
	cts_pkg::rec_t         wr_rec;
	// Queue read side, consumed by the back end.
	logic                  rd_en;
	cts_pkg::rec_t         head;
	cts_pkg::fifo_status_t stat;

	// Classifies each byte against the lookahead and builds the result record.
	cts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.source_byte (source_byte),
		.final_byte  (final_byte),
		.stat        (stat),
		.wr_en       (wr_en),
		.wr_rec      (wr_rec)
	);

	// Decouples the two sides so each may stall on its own.
	cts_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_rec (wr_rec),
		.rd_en  (rd_en),
		.head   (head),
		.stat   (stat)
	);

	// Walks the head record and presents its results in order.
	cts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.stat          (stat),
		.rd_en         (rd_en),
		.pop           (pop),
		.empty         (empty),
		.token_byte    (token_byte),
		.token_first   (token_first),
		.token_last    (token_last),
		.line_number   (line_number),
		.end_of_source (end_of_source),
		.run_last      (run_last)
	);

endmodule

// ===== test/c_style_token_splitter_test.sv =====
// Self-checking testbench of the C-style token splitter with its own token predictor.
module c_style_token_splitter_test;

	localparam int CLK_PERIOD   = 20;
	localparam int RANDOM_WORDS = 340;
	localparam int MAX_REPORTS  = 50;
	localparam logic [cts_pkg::LINE_BITS-1:0] LINE_TOP = '1;

	localparam logic [7:0] OP_CHARS [21] = '{cts_pkg::CH_PLUS, cts_pkg::CH_MINUS,
		cts_pkg::CH_STAR, cts_pkg::CH_SLASH, cts_pkg::CH_PCT, cts_pkg::CH_AMP,
		cts_pkg::CH_PIPE, cts_pkg::CH_CARET, cts_pkg::CH_EQ, cts_pkg::CH_LT,
		cts_pkg::CH_GT, cts_pkg::CH_BANG, cts_pkg::CH_TILDE, cts_pkg::CH_COMMA,
		cts_pkg::CH_SEMI, cts_pkg::CH_LBRACK, cts_pkg::CH_RBRACK, cts_pkg::CH_LPAREN,
		cts_pkg::CH_RPAREN, cts_pkg::CH_LBRACE, cts_pkg::CH_RBRACE};
	localparam logic [7:0] BLANKS [4] = '{cts_pkg::CH_SPACE, cts_pkg::CH_TAB,
		cts_pkg::CH_LF, cts_pkg::CH_CR};
	// The eight two-character operators, as first and second characters.
	localparam logic [7:0] PAIR_FIRST [8]  = '{cts_pkg::CH_PIPE, cts_pkg::CH_AMP,
		cts_pkg::CH_EQ, cts_pkg::CH_BANG, cts_pkg::CH_LT, cts_pkg::CH_GT,
		cts_pkg::CH_LT, cts_pkg::CH_GT};
	localparam logic [7:0] PAIR_SECOND [8] = '{cts_pkg::CH_PIPE, cts_pkg::CH_AMP,
		cts_pkg::CH_EQ, cts_pkg::CH_EQ, cts_pkg::CH_EQ, cts_pkg::CH_EQ,
		cts_pkg::CH_LT, cts_pkg::CH_GT};

	// One result word as it leaves the block, run_last included.
	typedef struct packed {
		logic [7:0]                    tok;
		logic                          first;
		logic                          last;
		logic [cts_pkg::LINE_BITS-1:0] line;
		logic                          eos;
		logic                          run_end;
	} token_word_t;

	// Token predictor and the queue of token words it still awaits from the block.
	class token_scoreboard;
		token_word_t                   awaited[$];
		token_word_t                   step_out[$];
		logic [7:0]                    la_byte;
		bit                            la_valid;
		logic [7:0]                    prev_byte;
		bit                            prev_valid;
		bit                            in_word;
		bit                            in_line_note;
		bit                            in_block_note;
		bit                            pair_tail_due;
		logic [cts_pkg::LINE_BITS-1:0] cur_line;
		bit                            op_char [256];
		int                            errors;
		int                            checked;

		function new();
			foreach (OP_CHARS[i]) op_char[OP_CHARS[i]] = 1'b1;
			errors  = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			la_byte       = 8'h00;
			la_valid      = 1'b0;
			prev_byte     = 8'h00;
			prev_valid    = 1'b0;
			in_word       = 1'b0;
			in_line_note  = 1'b0;
			in_block_note = 1'b0;
			pair_tail_due = 1'b0;
			cur_line      = cts_pkg::LINE_BITS'(1);
		endfunction

		function bit blank(logic [7:0] c);
			return c inside {cts_pkg::CH_SPACE, cts_pkg::CH_TAB, cts_pkg::CH_LF,
				cts_pkg::CH_CR};
		endfunction

		function bit pair_op(logic [7:0] a, logic [7:0] b);
			if (b == cts_pkg::CH_EQ)
				return a inside {cts_pkg::CH_EQ, cts_pkg::CH_BANG, cts_pkg::CH_LT,
					cts_pkg::CH_GT};
			return (a == b) && (a inside {cts_pkg::CH_PIPE, cts_pkg::CH_AMP,
				cts_pkg::CH_LT, cts_pkg::CH_GT});
		endfunction

		function void add_word(logic [7:0] c, bit first, bit last, bit eos);
			token_word_t w;
			w.tok     = c;
			w.first   = first;
			w.last    = last;
			w.line    = cur_line;
			w.eos     = eos;
			w.run_end = 1'b0;
			step_out.push_back(w);
		endfunction

		// Classifies one byte; nx is the byte after it when has_nx is set.
		function void classify(logic [7:0] c, bit has_nx, logic [7:0] nx);
			bit ends;
			if (pair_tail_due) begin
				pair_tail_due = 1'b0;
				add_word(c, 1'b0, 1'b1, 1'b0);
			end else if (in_line_note) begin
				if (c == cts_pkg::CH_LF)
					in_line_note = 1'b0;
			end else if (in_block_note) begin
				if (c == cts_pkg::CH_SLASH && prev_valid && prev_byte == cts_pkg::CH_STAR)
					in_block_note = 1'b0;
			end else if (!blank(c)) begin
				if (c == cts_pkg::CH_SLASH && has_nx && nx == cts_pkg::CH_SLASH) begin
					in_line_note = 1'b1;
				end else if (c == cts_pkg::CH_SLASH && has_nx && nx == cts_pkg::CH_STAR) begin
					in_block_note = 1'b1;
				end else if (has_nx && pair_op(c, nx)) begin
					pair_tail_due = 1'b1;
					add_word(c, 1'b1, 1'b0, 1'b0);
				end else if (op_char[c]) begin
					add_word(c, 1'b1, 1'b1, 1'b0);
				end else begin
					ends = !has_nx || blank(nx) || op_char[nx];
					add_word(c, !in_word, ends, 1'b0);
					in_word = !ends;
				end
			end
			if (c == cts_pkg::CH_LF && cur_line != LINE_TOP)
				cur_line = cur_line + cts_pkg::LINE_BITS'(1);
			prev_byte  = c;
			prev_valid = 1'b1;
		endfunction

		// Called for every source word the block accepts.
		function void note_word(logic [7:0] b, logic fin);
			step_out.delete();
			if (la_valid)
				classify(la_byte, 1'b1, b);
			if (fin) begin
				classify(b, 1'b0, 8'h00);
				add_word(8'h00, 1'b0, 1'b0, 1'b1);
				restart();
			end else begin
				la_byte  = b;
				la_valid = 1'b1;
			end
			if (step_out.size() > 0)
				step_out[step_out.size() - 1].run_end = 1'b1;
			foreach (step_out[i]) awaited.push_back(step_out[i]);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch at %0t: %s", $time, what);
		endtask

		// Called for every token word the block hands over.
		task check_word(token_word_t got);
			token_word_t want;
			checked++;
			if (awaited.size() == 0) begin
				report($sformatf("token word %02h arrived with nothing awaited", got.tok));
				return;
			end
			want = awaited.pop_front();
			// The byte field carries no meaning on the end-of-source word.
			if (!want.eos && got.tok !== want.tok)
				report($sformatf("token_byte %02h, predicted %02h", got.tok, want.tok));
			if (got.first !== want.first)
				report($sformatf("token_first %b, predicted %b", got.first, want.first));
			if (got.last !== want.last)
				report($sformatf("token_last %b, predicted %b", got.last, want.last));
			if (got.line !== want.line)
				report($sformatf("line_number %0d, predicted %0d", got.line, want.line));
			if (got.eos !== want.eos)
				report($sformatf("end_of_source %b, predicted %b", got.eos, want.eos));
			if (got.run_end !== want.run_end)
				report($sformatf("run_last %b, predicted %b", got.run_end, want.run_end));
		endtask
	endclass

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          push        = 1'b0;
	logic [7:0]                    source_byte = 8'h00;
	logic                          final_byte  = 1'b0;
	logic                          pop         = 1'b0;
	logic                          full;
	logic                          empty;
	logic [7:0]                    token_byte;
	logic                          token_first;
	logic                          token_last;
	logic [cts_pkg::LINE_BITS-1:0] line_number;
	logic                          end_of_source;
	logic                          run_last;

	token_scoreboard sb;
	logic [7:0]      src_q[$];
	bit              send_busy   = 1'b0;
	bit              recv_busy   = 1'b0;
	int              stall_left  = 0;
	int              words_sent  = 0;
	int              sources     = 0;
	int              rand_start;

	c_style_token_splitter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.source_byte  (source_byte),
		.final_byte   (final_byte),
		.empty        (empty),
		.pop          (pop),
		.token_byte   (token_byte),
		.token_first  (token_first),
		.token_last   (token_last),
		.line_number  (line_number),
		.end_of_source(end_of_source),
		.run_last     (run_last)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Length of one idle stretch. Most are zero or short, a few are long, and a side
	// that is not busy never idles at all.
	function automatic int idle_len(bit busy);
		int r;
		if (!busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The receiving side. Pop is held low for an idle stretch after each high cycle;
	// with zero-length stretches it stays high for as long as the receiver is eager.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = idle_len(recv_busy);
			end
		end
	end

	// Every token word the block hands over is checked here. All inputs are driven
	// with nonblocking assignments at the edge, so the values read at an edge are
	// the ones that were set up during the cycle before it.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word('{token_byte, token_first, token_last, line_number,
				end_of_source, run_last});
	end

	// Offers one source word after an optional gap and waits until it is taken. Push
	// stays high on return, so a following word with no gap goes out back to back.
	// The word is noted at the edge that accepts it, before any of its token words
	// can be popped.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_len(send_busy);
		repeat (gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		source_byte <= b;
		final_byte  <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_word(b, fin);
		words_sent++;
	endtask

	// Sends the whole source text held in src_q, the last word flagged as final.
	task automatic send_source();
		foreach (src_q[i]) send_byte(src_q[i], i == src_q.size() - 1);
		sources++;
	endtask

	// Holds the sender off until every predicted token word has been popped.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic void load_text(string s);
		for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
	endfunction

	// A word character: usually a plain letter or digit, otherwise any byte value
	// that is neither whitespace nor an operator character.
	function automatic logic [7:0] word_char();
		string      pool;
		logic [7:0] c;
		pool = "abqXZ_09$.";
		if ($urandom_range(0, 1))
			return pool[$urandom_range(0, pool.len() - 1)];
		do begin
			c = 8'($urandom_range(0, 255));
		end while (sb.blank(c) || sb.op_char[c]);
		return c;
	endfunction

	// A source built from well-formed tokens, comments and whitespace with random
	// content. Its length is random, so the final word often cuts a token or a
	// comment short, which exercises the flush at the end of a source.
	function automatic void make_source();
		int target;
		int k;
		logic [7:0] line_fill [4];
		logic [7:0] block_fill [4];
		line_fill  = '{"a", cts_pkg::CH_SPACE, cts_pkg::CH_STAR, cts_pkg::CH_SLASH};
		block_fill = '{"a", cts_pkg::CH_SPACE, cts_pkg::CH_STAR, cts_pkg::CH_LF};
		src_q.delete();
		target = $urandom_range(2, 30);
		while (src_q.size() < target) begin
			case ($urandom_range(0, 7))
				0, 7: begin
					repeat ($urandom_range(1, 4)) src_q.push_back(word_char());
				end
				1: begin
					k = $urandom_range(0, 7);
					src_q.push_back(PAIR_FIRST[k]);
					src_q.push_back(PAIR_SECOND[k]);
				end
				2: src_q.push_back(OP_CHARS[$urandom_range(0, 20)]);
				3: src_q.push_back(BLANKS[$urandom_range(0, 3)]);
				4: begin
					src_q.push_back(cts_pkg::CH_SLASH);
					src_q.push_back(cts_pkg::CH_SLASH);
					repeat ($urandom_range(0, 4)) src_q.push_back(line_fill[$urandom_range(0, 3)]);
					src_q.push_back(cts_pkg::CH_LF);
				end
				5: begin
					src_q.push_back(cts_pkg::CH_SLASH);
					src_q.push_back(cts_pkg::CH_STAR);
					repeat ($urandom_range(0, 4))
						src_q.push_back(block_fill[$urandom_range(0, 3)]);
					src_q.push_back(cts_pkg::CH_STAR);
					src_q.push_back(cts_pkg::CH_SLASH);
				end
				default: src_q.push_back(cts_pkg::CH_LF);
			endcase
		end
	endfunction

	// A short source of arbitrary byte values.
	function automatic void make_noise();
		src_q.delete();
		repeat ($urandom_range(1, 12)) src_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sources, sent without idling on either side. The first has a
		// word, a block comment closed by the slash-star-slash shortcut, a word
		// ended by an operator, and a line comment whose newline is the final
		// word.
		src_q.delete();
		load_text("a/*/b//c\n");
		send_source();
		// All eight two-character operators; the last one ends on the final word.
		src_q.delete();
		load_text("<<&&||>>!===<=>=");
		send_source();
		// A lone slash as the final word is a plain operator.
		src_q.delete();
		load_text("/");
		send_source();
		// Extreme byte values as word characters, then a block comment that never
		// closes before the end of the source.
		src_q = '{8'hFF, 8'h00};
		load_text("|/*");
		send_source();
		drain_results();

		// Random sources: mostly well-formed token streams, some pure noise. Idling
		// changes from one source to the next, including stretches with none, and
		// now and then the sender waits until the block has delivered everything.
		rand_start = words_sent;
		while (words_sent - rand_start < RANDOM_WORDS) begin
			send_busy = ($urandom_range(0, 3) != 0);
			recv_busy = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				drain_results();
			if ($urandom_range(0, 4) == 0)
				make_noise();
			else
				make_source();
			send_source();
		end

		// Let the last token words out, then give the block time to show any extra.
		drain_results();
		repeat (20) @(posedge clk);

		$display("Run covered %0d source words in %0d sources, comments and operators included.",
			words_sent, sources);
		$display("%0d token words checked, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Guard against a block that stops handing over words or stops taking them.
	initial begin
		#(CLK_PERIOD * 1000000);
		$display("Run stopped by the time limit.");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
